// ===== design/cq_pkg.sv =====
`timescale 1ns / 1ps

package cq_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int IDX_W  = 4;

	// operation codes
	localparam logic [1:0] FUNC_ENQ  = 2'd0;
	localparam logic [1:0] FUNC_DEQ  = 2'd1;
	localparam logic [1:0] FUNC_SHOW = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
		logic [IDX_W-1:0]         head_index;
		logic [IDX_W-1:0]         tail_index;
		logic                     is_empty;
	} res_t;

endpackage

// ===== design/cq_ram.sv =====
`timescale 1ns / 1ps

module cq_ram #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [cq_pkg::DATA_W-1:0]  wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [cq_pkg::DATA_W-1:0]  rdata
);

	logic [cq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [cq_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/circular_queue.sv =====
`timescale 1ns / 1ps
// Ring-buffer FIFO of 32-bit words, capacity set by a register.
// Enqueue, dequeue: one item per cycle when idle; result via stage 1, output reg.
// Show of n entries: busy while walking, one result per cycle via SHOW, stage 1
// and output register; throughput is set by the single read port of the ring RAM.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset (arst_n low): queue empty, head and tail 0, capacity min(16, DEPTH).

module circular_queue #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  cq_pkg::req_t              req,
	output logic                      done,
	output cq_pkg::res_t              res,
	input  logic                      cfg_we,
	input  logic [cq_pkg::CAP_W-1:0]  cfg_wdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CMP_W = (PTR_W + 1 > cq_pkg::CAP_W) ? PTR_W + 1 : cq_pkg::CAP_W;
	localparam int EXT_W = PTR_W + cq_pkg::IDX_W;
	localparam int CNT_W = $clog2(DEPTH);
	localparam logic [cq_pkg::CAP_W-1:0] CAP_RST =
		cq_pkg::CAP_W'((DEPTH < 16) ? DEPTH : 16);

	// One-hot sequencer: IDLE takes items, SHOW walks the ring.
	typedef enum logic [1:0] {
		IDLE = 2'b01,
		SHOW = 2'b10
	} state_t;

	state_t                    state_q;
	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          tail_q;
	logic                      empty_q;
	logic [cq_pkg::CAP_W-1:0]  cap_q;
	logic [PTR_W-1:0]          walk_q;
	logic [CNT_W-1:0]          cnt_q;

	// Result held in stage 1 while the RAM read data lands.
	logic                      emit_s1;
	logic [1:0]                status_s1;
	logic                      use_mem_s1;
	logic                      last_s1;

	logic                      emit_d;
	logic [1:0]                status_d;
	logic                      use_mem_d;
	logic                      last_d;

	logic                      done_q;
	cq_pkg::res_t              res_q;

	logic                      accept;
	logic                      full;
	logic [PTR_W-1:0]          tail_next;
	logic [PTR_W-1:0]          head_next;
	logic [PTR_W-1:0]          walk_next;
	logic                      walk_fin;
	logic                      ram_we;
	logic [PTR_W-1:0]          ram_waddr;
	logic                      ram_re;
	logic [PTR_W-1:0]          ram_raddr;
	logic [cq_pkg::DATA_W-1:0] ram_rdata;
	logic [cq_pkg::CAP_W-1:0]  cap_clamped;
	logic [EXT_W-1:0]          head_ext;
	logic [EXT_W-1:0]          tail_ext;

	// Advance a slot, wrapping at the capacity in use.
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
			input logic [cq_pkg::CAP_W-1:0] cap);
		logic [PTR_W:0] n;
		n = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
		if (CMP_W'(n) >= CMP_W'(cap)) begin
			return '0;
		end
		return n[PTR_W-1:0];
	endfunction

	assign busy   = (state_q == SHOW);
	assign accept = start && !busy;

	assign tail_next = next_slot(tail_q, cap_q);
	assign head_next = next_slot(head_q, cap_q);
	assign walk_next = next_slot(walk_q, cap_q);
	assign full      = !empty_q && (head_q == tail_next);
	assign walk_fin  = (walk_q == tail_q) || (cnt_q == CNT_W'(DEPTH - 1));

	// Clamp a written capacity to 1..DEPTH.
	always_comb begin
		cap_clamped = cfg_wdata;
		if (cfg_wdata == '0) begin
			cap_clamped = cq_pkg::CAP_W'(1);
		end else if (CMP_W'(cfg_wdata) > CMP_W'(DEPTH)) begin
			cap_clamped = cq_pkg::CAP_W'(DEPTH);
		end
	end

	// Enqueue writes at slot 0 on an empty ring, else after the tail.
	assign ram_we    = accept && (req.func == cq_pkg::FUNC_ENQ) && !full;
	assign ram_waddr = empty_q ? '0 : tail_next;

	// Read the head for a dequeue, the walk pointer while showing.
	assign ram_re    = (accept && (req.func == cq_pkg::FUNC_DEQ) && !empty_q) ||
		(state_q == SHOW);
	assign ram_raddr = (state_q == SHOW) ? walk_q : head_q;

	cq_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pointer state and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			cap_q   <= CAP_RST;
			walk_q  <= '0;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			// a capacity write empties the queue; stored words stay
			cap_q   <= cap_clamped;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						case (req.func)
							cq_pkg::FUNC_ENQ: begin
								if (!full) begin
									if (empty_q) begin
										head_q <= '0;
										tail_q <= '0;
									end else begin
										tail_q <= tail_next;
									end
									empty_q <= 1'b0;
								end
							end
							cq_pkg::FUNC_DEQ: begin
								if (!empty_q) begin
									if (head_q == tail_q) begin
										// last entry leaves: drop to empty
										head_q  <= '0;
										tail_q  <= '0;
										empty_q <= 1'b1;
									end else begin
										head_q <= head_next;
									end
								end
							end
							cq_pkg::FUNC_SHOW: begin
								if (!empty_q) begin
									walk_q  <= head_q;
									cnt_q   <= '0;
									state_q <= SHOW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				SHOW: begin
					walk_q <= walk_next;
					cnt_q  <= cnt_q + CNT_W'(1);
					if (walk_fin) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Decide which result goes out; a non-empty show answers only from the walk.
	always_comb begin
		emit_d    = 1'b0;
		status_d  = cq_pkg::ST_OK;
		use_mem_d = 1'b0;
		last_d    = 1'b1;
		if (state_q == SHOW) begin
			emit_d    = 1'b1;
			use_mem_d = 1'b1;
			last_d    = walk_fin;
		end else if (accept) begin
			case (req.func)
				cq_pkg::FUNC_ENQ: begin
					emit_d = 1'b1;
					if (full) begin
						status_d = cq_pkg::ST_FULL;
					end
				end
				cq_pkg::FUNC_DEQ: begin
					emit_d = 1'b1;
					if (empty_q) begin
						status_d = cq_pkg::ST_EMPTY;
					end else begin
						use_mem_d = 1'b1;
					end
				end
				cq_pkg::FUNC_SHOW: begin
					if (empty_q) begin
						emit_d   = 1'b1;
						status_d = cq_pkg::ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1: hold the result until the RAM data is back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_d) begin
			status_s1  <= status_d;
			use_mem_s1 <= use_mem_d;
			last_s1    <= last_d;
		end
	end

	// Output register: pointers already hold their post-operation values here.
	assign head_ext = EXT_W'(head_q);
	assign tail_ext = EXT_W'(tail_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1) begin
			res_q.status     <= status_s1;
			res_q.data       <= use_mem_s1 ? ram_rdata : '0;
			res_q.last       <= last_s1;
			res_q.head_index <= head_ext[cq_pkg::IDX_W-1:0];
			res_q.tail_index <= tail_ext[cq_pkg::IDX_W-1:0];
			res_q.is_empty   <= empty_q;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
